// ===== rtl/core/tws_pkg.sv =====
// Shared types and constants of the time window schedule table.
`default_nettype none

package tws_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int SUM_W = 9;
    localparam int SEC_W = 17;

    typedef enum logic [1:0] {
        OP_ADD_WEEKLY = 2'd0,
        OP_ADD_DATED  = 2'd1,
        OP_CHECK      = 2'd2,
        OP_CLEAR      = 2'd3
    } op_t;

    // One stored window; unused day fields are held at zero.
    typedef struct packed {
        logic             dated;
        logic [3:0]       rec_tag;
        logic [2:0]       weekday;
        logic [11:0]      year;
        logic [3:0]       month;
        logic [4:0]       day_of_month;
        logic [SEC_W-1:0] seg_end;
        logic [SEC_W-1:0] seg_start;
    } window_t;

    localparam int REC_W = $bits(window_t);

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        window_t           wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic [SUM_W-1:0] active_sum;
        logic             merged;
        logic             dropped;
    } result_t;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] fill;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/time_window_schedule_table_unit.sv =====
// Top level of the time window schedule table: sequencer, table memory, output register.
`default_nettype none

// The table holds up to TABLE_DEPTH (32) weekly or dated windows in one synchronous
// memory; a fill count marks the stored entries, so no clearing pass follows reset.
// One request is worked on at a time. An add or a check streams the stored entries
// out of the memory at one entry a cycle; an add that merges stops at the absorbing
// entry. A clear, and any request on an empty table, goes straight to the result
// without a scan. The result sits in an output register, and the next request is
// taken while it waits to be collected.

module time_window_schedule_table_unit
    import tws_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [1:0]       kind,
    input  wire logic [3:0]       rec_tag,
    input  wire logic [2:0]       weekday,
    input  wire logic [11:0]      year,
    input  wire logic [3:0]       month,
    input  wire logic [4:0]       day_of_month,
    input  wire logic [SEC_W-1:0] seg_start,
    input  wire logic [SEC_W-1:0] seg_end,
    input  wire logic [SEC_W-1:0] now_seconds,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [SUM_W-1:0]      active_sum,
    output logic                  merged,
    output logic                  dropped
);

    mem_req_t mem_req;
    window_t  rdata;
    status_t  stat;
    result_t  res;
    logic     res_valid;
    logic     res_ready;
    logic     out_valid_reg;
    result_t  out_reg;

    tws_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .rec_tag      (rec_tag),
        .weekday      (weekday),
        .year         (year),
        .month        (month),
        .day_of_month (day_of_month),
        .seg_start    (seg_start),
        .seg_end      (seg_end),
        .now_seconds  (now_seconds),
        .res_ready    (res_ready),
        .res_valid    (res_valid),
        .res          (res),
        .mem_req      (mem_req),
        .rdata        (rdata),
        .stat         (stat)
    );

    tws_mem #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (REC_W),
        .AW    (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (rdata)
    );

    // Load a finished result once the previous one has gone.
    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= res;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign active_sum = out_reg.active_sum;
    assign merged     = out_reg.merged;
    assign dropped    = out_reg.dropped;

`ifndef NO_ASSERTIONS
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> stat.busy)
        else $error("table written while no request is in progress");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.fill <= CNT_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_write_addr: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> (CNT_W'(mem_req.waddr) <= stat.fill))
        else $error("write beyond the stored entries");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> stat.busy)
        else $error("accepted request did not start work");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/tws_mem.sv =====
// Single-port-write, single-port-read table memory with registered read data.
`default_nettype none

module tws_mem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 63,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tws_ctrl.sv =====
// Scan sequencer: streams table entries, merges, stores and sums windows.
`default_nettype none

module tws_ctrl
    import tws_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [1:0]       kind,
    input  wire logic [3:0]       rec_tag,
    input  wire logic [2:0]       weekday,
    input  wire logic [11:0]      year,
    input  wire logic [3:0]       month,
    input  wire logic [4:0]       day_of_month,
    input  wire logic [SEC_W-1:0] seg_start,
    input  wire logic [SEC_W-1:0] seg_end,
    input  wire logic [SEC_W-1:0] now_seconds,
    input  wire logic             res_ready,
    output logic                  res_valid,
    output result_t               res,
    output mem_req_t              mem_req,
    input  wire window_t          rdata,
    output status_t               stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    op_t               op_reg, op_next;
    window_t           item_reg, item_next;
    logic [SEC_W-1:0]  now_reg, now_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic              dv_reg, dv_next;
    logic [ADDR_W-1:0] daddr_reg, daddr_next;
    logic              dlast_reg, dlast_next;
    logic              merged_reg, merged_next;
    logic [SUM_W-1:0]  sum_dated_reg, sum_dated_next;
    logic [SUM_W-1:0]  sum_weekly_reg, sum_weekly_next;

    op_t               in_op;
    window_t           new_win;
    window_t           widened;
    logic              same_key;
    logic              touches;
    logic              contains;
    logic              dated_hit;
    logic              weekly_hit;
    logic              is_add;
    logic              table_full;
    logic [CNT_W-1:0]  rev_idx;
    logic [ADDR_W-1:0] issue_addr;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [3:0] b);
        logic [SUM_W:0] t;
        t = {1'b0, a} + (SUM_W + 1)'(b);
        return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
    endfunction

    // Windows that come back from the memory are compared against the held item.
    always_comb
    begin
        in_op = op_t'(kind);

        new_win.dated        = (in_op == OP_ADD_DATED);
        new_win.rec_tag      = rec_tag;
        new_win.weekday      = (in_op == OP_ADD_DATED) ? 3'd0 : weekday;
        new_win.year         = (in_op == OP_ADD_WEEKLY) ? 12'd0 : year;
        new_win.month        = (in_op == OP_ADD_WEEKLY) ? 4'd0 : month;
        new_win.day_of_month = (in_op == OP_ADD_WEEKLY) ? 5'd0 : day_of_month;
        new_win.seg_start    = seg_start;
        new_win.seg_end      = seg_end;

        same_key = (rdata.dated == item_reg.dated)
                && (rdata.rec_tag == item_reg.rec_tag)
                && (rdata.weekday == item_reg.weekday)
                && (rdata.year == item_reg.year)
                && (rdata.month == item_reg.month)
                && (rdata.day_of_month == item_reg.day_of_month);
        touches = (rdata.seg_start <= item_reg.seg_end)
               && (item_reg.seg_start <= rdata.seg_end);

        widened = rdata;
        if (item_reg.seg_start < rdata.seg_start)
        begin
            widened.seg_start = item_reg.seg_start;
        end
        if (item_reg.seg_end > rdata.seg_end)
        begin
            widened.seg_end = item_reg.seg_end;
        end

        contains = (now_reg >= rdata.seg_start) && (now_reg < rdata.seg_end);
        dated_hit = rdata.dated && (rdata.year == item_reg.year)
                 && (rdata.month == item_reg.month)
                 && (rdata.day_of_month == item_reg.day_of_month) && contains;
        weekly_hit = !rdata.dated && (rdata.weekday == item_reg.weekday) && contains;

        is_add = (op_reg == OP_ADD_WEEKLY) || (op_reg == OP_ADD_DATED);
        table_full = (fill_reg == CNT_W'(TABLE_DEPTH));

        rev_idx = fill_reg - k_reg - CNT_W'(1);
        issue_addr = (op_reg == OP_ADD_DATED) ? rev_idx[ADDR_W-1:0] : k_reg[ADDR_W-1:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        op_next         = op_reg;
        item_next       = item_reg;
        now_next        = now_reg;
        k_next          = k_reg;
        dv_next         = 1'b0;
        daddr_next      = daddr_reg;
        dlast_next      = dlast_reg;
        merged_next     = merged_reg;
        sum_dated_next  = sum_dated_reg;
        sum_weekly_next = sum_weekly_reg;

        mem_req   = '0;
        res       = '0;
        res_valid = 1'b0;
        in_stall  = (state_reg != S_IDLE);
        stat.busy = (state_reg != S_IDLE);
        stat.fill = fill_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = in_op;
                    item_next       = new_win;
                    now_next        = now_seconds;
                    k_next          = '0;
                    merged_next     = 1'b0;
                    sum_dated_next  = '0;
                    sum_weekly_next = '0;
                    if (in_op == OP_CLEAR)
                    begin
                        fill_next  = '0;
                        state_next = S_DONE;
                    end
                    else if (fill_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Issue one read a cycle until every stored entry is requested.
                if (k_reg < fill_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = issue_addr;
                    k_next        = k_reg + CNT_W'(1);
                    dv_next       = 1'b1;
                    daddr_next    = issue_addr;
                    dlast_next    = (k_reg == fill_reg - CNT_W'(1));
                end

                if (dv_reg)
                begin
                    if (is_add)
                    begin
                        if (same_key && touches)
                        begin
                            // Widen the stored window and drop the rest of the scan.
                            mem_req.we    = 1'b1;
                            mem_req.waddr = daddr_reg;
                            mem_req.wdata = widened;
                            merged_next   = 1'b1;
                            state_next    = S_DONE;
                        end
                        else if (dlast_reg)
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        if (dated_hit)
                        begin
                            sum_dated_next = sat_add(sum_dated_reg, rdata.rec_tag);
                        end
                        if (weekly_hit)
                        begin
                            sum_weekly_next = sat_add(sum_weekly_reg, rdata.rec_tag);
                        end
                        if (dlast_reg)
                        begin
                            state_next = S_DONE;
                        end
                    end
                end
            end

            S_DONE:
            begin
                res_valid      = 1'b1;
                res.merged     = is_add && merged_reg;
                res.dropped    = is_add && !merged_reg && table_full;
                res.active_sum = (op_reg != OP_CHECK) ? '0
                               : (sum_dated_reg != '0) ? sum_dated_reg : sum_weekly_reg;
                if (res_ready)
                begin
                    if (is_add && !merged_reg && !table_full)
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = fill_reg[ADDR_W-1:0];
                        mem_req.wdata = item_reg;
                        fill_next     = fill_reg + CNT_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            op_reg         <= OP_CLEAR;
            item_reg       <= '0;
            now_reg        <= '0;
            k_reg          <= '0;
            dv_reg         <= 1'b0;
            daddr_reg      <= '0;
            dlast_reg      <= 1'b0;
            merged_reg     <= 1'b0;
            sum_dated_reg  <= '0;
            sum_weekly_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            op_reg         <= op_next;
            item_reg       <= item_next;
            now_reg        <= now_next;
            k_reg          <= k_next;
            dv_reg         <= dv_next;
            daddr_reg      <= daddr_next;
            dlast_reg      <= dlast_next;
            merged_reg     <= merged_next;
            sum_dated_reg  <= sum_dated_next;
            sum_weekly_reg <= sum_weekly_next;
        end
    end

endmodule

`default_nettype wire
